// ----- src/prds_pkg.sv -----
// Shared types, constants and helper functions for the retry-deadline scheduler.
package prds_pkg;

    // Width of every time value, peer address and register.
    localparam int unsigned DATA_W = 32;
    // Number of neighbour slots and the width of a slot index.
    localparam int unsigned SLOTS  = 16;
    localparam int unsigned SLOT_W = 4;
    // Configuration address width: two 32-bit registers at byte addresses 0 and 4.
    localparam int unsigned ADDR_W = 3;

    // Register reset values.
    localparam logic [DATA_W-1:0] SWEEP_INTERVAL_RST = 32'd60000;
    localparam logic [DATA_W-1:0] COOLDOWN_RST       = 32'd30000;

    // Register indexes, taken from paddr[2].
    localparam logic REG_SWEEP_INTERVAL = 1'b0;
    localparam logic REG_COOLDOWN       = 1'b1;

    // Event codes.
    typedef enum logic [2:0] {
        REQ_SWEEP_CHECK  = 3'd0,
        REQ_SWEPT        = 3'd1,
        REQ_SKIPPED      = 3'd2,
        REQ_DEFER_QUERY  = 3'd3,
        REQ_ARM          = 3'd4,
        REQ_BEACON       = 3'd5,
        REQ_FLUSHED      = 3'd6,
        REQ_SLOT_CLEARED = 3'd7
    } t_req_type;

    // One event as held in the input register.
    typedef struct packed {
        t_req_type          req_type;
        logic [DATA_W-1:0]  peer_address;
        logic [SLOT_W-1:0]  slot_index;
        logic               slot_present;
        logic               newly_admitted;
        logic               rows_found;
        logic [DATA_W-1:0]  now_time;
    } t_req;

    // Configuration values handed from the register file to the core.
    typedef struct packed {
        logic [DATA_W-1:0] sweep_interval_ms;
        logic [DATA_W-1:0] cooldown_ms;
    } t_cfg;

    // A computed deadline of zero is stored as one, so it never reads as disarmed.
    function automatic logic [DATA_W-1:0] nudge(input logic [DATA_W-1:0] t);
        nudge = (t != '0) ? t : {{(DATA_W-1){1'b0}}, 1'b1};
    endfunction

    // A deadline has elapsed when the wrapping signed difference is not negative.
    function automatic logic passed(input logic [DATA_W-1:0] now,
                                    input logic [DATA_W-1:0] deadline);
        logic [DATA_W-1:0] diff;
        diff   = now - deadline;
        passed = ~diff[DATA_W-1];
    endfunction

endpackage

// ----- src/prds_cfg.sv -----
// APB-style configuration register file holding the sweep interval and cooldown.
module prds_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prds_pkg::ADDR_W-1:0]   paddr,
    input  logic [prds_pkg::DATA_W-1:0]   pwdata,
    output logic [prds_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output prds_pkg::t_cfg                o_cfg
);

    logic [prds_pkg::DATA_W-1:0] r_sweep_interval;
    logic [prds_pkg::DATA_W-1:0] r_cooldown;
    logic                        wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes complete on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_interval <= prds_pkg::SWEEP_INTERVAL_RST;
            r_cooldown       <= prds_pkg::COOLDOWN_RST;
        end else if (wr_en) begin
            if (paddr[2] == prds_pkg::REG_SWEEP_INTERVAL) begin
                r_sweep_interval <= pwdata;
            end else begin
                r_cooldown <= pwdata;
            end
        end
    end

    // Read data follows the selected register.
    assign prdata = (paddr[2] == prds_pkg::REG_COOLDOWN) ? r_cooldown : r_sweep_interval;

    assign o_cfg.sweep_interval_ms = r_sweep_interval;
    assign o_cfg.cooldown_ms       = r_cooldown;

endmodule

// ----- src/prds_core.sv -----
// Scheduler state and the single-pass event logic that reads and updates it.
module prds_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  prds_pkg::t_req  i_req,
    input  prds_pkg::t_cfg  i_cfg,
    output logic            o_answer
);

    logic [prds_pkg::DATA_W-1:0] r_next_sweep;
    logic [prds_pkg::DATA_W-1:0] r_held_peer;
    logic [prds_pkg::DATA_W-1:0] r_hold_end;
    logic [prds_pkg::DATA_W-1:0] r_deadline [prds_pkg::SLOTS];

    logic [prds_pkg::DATA_W-1:0] n_next_sweep;
    logic [prds_pkg::DATA_W-1:0] n_held_peer;
    logic [prds_pkg::DATA_W-1:0] n_hold_end;
    logic [prds_pkg::DATA_W-1:0] n_deadline;
    logic                        dl_we;

    logic                        in_range;
    logic                        present;
    logic [prds_pkg::SLOT_W-1:0] idx;
    logic [prds_pkg::DATA_W-1:0] cur_dl;
    logic                        peer_held;
    logic                        answer;

    // Slot decode: an index beyond the table counts as absent.
    assign in_range = ({{(32-prds_pkg::SLOT_W){1'b0}}, i_req.slot_index} < 32'(prds_pkg::SLOTS));
    assign present  = i_req.slot_present & in_range;
    assign idx      = in_range ? i_req.slot_index : '0;
    assign cur_dl   = r_deadline[idx];

    // A beacon comes from the held peer while its cooldown is still running.
    assign peer_held = (i_req.peer_address != '0) && (i_req.peer_address == r_held_peer) &&
                       (r_hold_end != '0) && !prds_pkg::passed(i_req.now_time, r_hold_end);

    // Event decode: next state and the answer for this event.
    always_comb begin
        n_next_sweep = r_next_sweep;
        n_held_peer  = r_held_peer;
        n_hold_end   = r_hold_end;
        n_deadline   = cur_dl;
        dl_we        = 1'b0;
        answer       = 1'b0;
        unique case (i_req.req_type)
            prds_pkg::REQ_SWEEP_CHECK: begin
                if (prds_pkg::passed(i_req.now_time, r_next_sweep)) begin
                    n_next_sweep = prds_pkg::nudge(i_req.now_time + i_cfg.sweep_interval_ms);
                    answer       = 1'b1;
                end
            end
            prds_pkg::REQ_SWEPT: begin
                n_held_peer = i_req.peer_address;
                n_hold_end  = prds_pkg::nudge(i_req.now_time + i_cfg.cooldown_ms);
            end
            prds_pkg::REQ_SKIPPED: begin
                n_held_peer = i_req.peer_address;
                n_hold_end  = '0;
            end
            prds_pkg::REQ_DEFER_QUERY: begin
                answer = present && (cur_dl != '0);
            end
            prds_pkg::REQ_ARM: begin
                if (present) begin
                    n_deadline = prds_pkg::nudge(i_req.now_time);
                    dl_we      = 1'b1;
                    answer     = 1'b1;
                end
            end
            prds_pkg::REQ_BEACON: begin
                if (peer_held) begin
                    // Defer to the hold end, never pulling a deadline earlier.
                    if (present && ((cur_dl == '0) || prds_pkg::passed(r_hold_end, cur_dl))) begin
                        n_deadline = r_hold_end;
                        dl_we      = 1'b1;
                    end
                end else if (i_req.newly_admitted) begin
                    answer = 1'b1;
                end else if (present && (cur_dl != '0)) begin
                    answer = prds_pkg::passed(i_req.now_time, cur_dl);
                end
            end
            prds_pkg::REQ_FLUSHED: begin
                if (present) begin
                    n_deadline = i_req.rows_found ?
                                 prds_pkg::nudge(i_req.now_time + i_cfg.cooldown_ms) : '0;
                    dl_we      = 1'b1;
                end
            end
            prds_pkg::REQ_SLOT_CLEARED: begin
                if (in_range) begin
                    n_deadline = '0;
                    dl_we      = 1'b1;
                end
            end
        endcase
    end

    // Sweep and hold state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_sweep <= '0;
            r_held_peer  <= '0;
            r_hold_end   <= '0;
        end else if (i_fire) begin
            r_next_sweep <= n_next_sweep;
            r_held_peer  <= n_held_peer;
            r_hold_end   <= n_hold_end;
        end
    end

    // Per-slot retry deadlines, all disarmed after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(prds_pkg::SLOTS); i++) begin
                r_deadline[i] <= '0;
            end
        end else if (i_fire && dl_we) begin
            r_deadline[idx] <= n_deadline;
        end
    end

    assign o_answer = answer;

endmodule

// ----- src/parked_retry_deadline_scheduler_top.sv -----
// Top level of the parked-message retry-deadline scheduler: handshakes and pipeline registers.
// Each accepted event gives exactly one answer. An event is captured in an input register,
// decoded against the scheduler state in one pass, and its answer lands in an output register
// that offers it on the answer channel. The block takes one event every cycle while the result
// side keeps up; the single state-update stage sets that rate, and a stalled output holds the
// pipeline. Configuration writes over the APB port take effect for events decoded after the
// write completes.
module parked_retry_deadline_scheduler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Event channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_req_type,
    input  logic [prds_pkg::DATA_W-1:0]   i_peer_address,
    input  logic [prds_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic                          i_slot_present,
    input  logic                          i_newly_admitted,
    input  logic                          i_rows_found,
    input  logic [prds_pkg::DATA_W-1:0]   i_now_time,
    // Answer channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_answer,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prds_pkg::ADDR_W-1:0]   paddr,
    input  logic [prds_pkg::DATA_W-1:0]   pwdata,
    output logic [prds_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    prds_pkg::t_cfg cfg;
    prds_pkg::t_req r_req;
    logic           r_in_valid;
    logic           r_out_valid;
    logic           r_answer;
    logic           advance;
    logic           core_answer;

    prds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The held event moves on when the output register is free or being emptied.
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;

    // Input register: control bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register: event payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req.req_type       <= prds_pkg::t_req_type'(i_req_type);
            r_req.peer_address   <= i_peer_address;
            r_req.slot_index     <= i_slot_index;
            r_req.slot_present   <= i_slot_present;
            r_req.newly_admitted <= i_newly_admitted;
            r_req.rows_found     <= i_rows_found;
            r_req.now_time       <= i_now_time;
        end
    end

    prds_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_req    (r_req),
        .i_cfg    (cfg),
        .o_answer (core_answer)
    );

    // Output register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: answer bit.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_answer <= core_answer;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;

endmodule

// ----- tb/tb_parked_retry_deadline_scheduler_top.sv -----
// Self-checking testbench for the parked-message retry-deadline scheduler top level.
module tb_parked_retry_deadline_scheduler_top;

    import prds_pkg::*;

    localparam int unsigned NUM_DIRECTED = 25;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned PHASE_ITEMS  = 175;
    localparam int unsigned MAX_REPORTS  = 10;

    // One row of the directed table: the event and, where it is obvious, its answer.
    typedef struct packed {
        t_req ev;
        logic typed;
        logic answer;
    } t_directed_row;

    // An answer waiting to come out, with the kind of event that caused it.
    typedef struct {
        t_req_type kind;
        logic      answer;
    } t_awaited_answer;

    // Directed events: reset state, time extremes, wrap-around, holds and deadlines.
    localparam t_directed_row DIRECTED [NUM_DIRECTED] = '{
        '{'{REQ_SWEEP_CHECK,  32'h0000_0000, 4'd0,  1'b0, 1'b0, 1'b0, 32'h0000_0000}, 1'b1, 1'b1},
        '{'{REQ_SWEEP_CHECK,  32'h0000_0000, 4'd0,  1'b0, 1'b0, 1'b0, 32'h0000_0064}, 1'b1, 1'b0},
        '{'{REQ_ARM,          32'h0000_0000, 4'd15, 1'b1, 1'b0, 1'b0, 32'h0000_0000}, 1'b1, 1'b1},
        '{'{REQ_ARM,          32'h0000_0000, 4'd3,  1'b0, 1'b0, 1'b0, 32'h0000_0005}, 1'b1, 1'b0},
        '{'{REQ_DEFER_QUERY,  32'h0000_0000, 4'd15, 1'b1, 1'b0, 1'b0, 32'h0000_0005}, 1'b1, 1'b1},
        '{'{REQ_DEFER_QUERY,  32'h0000_0000, 4'd15, 1'b0, 1'b0, 1'b0, 32'h0000_0005}, 1'b1, 1'b0},
        '{'{REQ_BEACON,       32'h0000_0000, 4'd4,  1'b0, 1'b1, 1'b0, 32'h0000_000A}, 1'b1, 1'b1},
        '{'{REQ_BEACON,       32'h1234_5678, 4'd15, 1'b1, 1'b0, 1'b0, 32'h0000_000A}, 1'b0, 1'b0},
        '{'{REQ_SWEPT,        32'hFFFF_FFFF, 4'd0,  1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b1, 1'b0},
        '{'{REQ_BEACON,       32'hFFFF_FFFF, 4'd15, 1'b1, 1'b0, 1'b0, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{REQ_BEACON,       32'hFFFF_FFFF, 4'd4,  1'b1, 1'b1, 1'b0, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{REQ_ARM,          32'h0000_0000, 4'd6,  1'b1, 1'b0, 1'b0, 32'h0000_C350}, 1'b1, 1'b1},
        '{'{REQ_BEACON,       32'hFFFF_FFFF, 4'd6,  1'b1, 1'b0, 1'b0, 32'h0000_0064}, 1'b1, 1'b0},
        '{'{REQ_BEACON,       32'h0000_0001, 4'd6,  1'b1, 1'b0, 1'b0, 32'h0000_C34F}, 1'b0, 1'b0},
        '{'{REQ_SWEPT,        32'h0000_00AA, 4'd0,  1'b0, 1'b0, 1'b0, 32'hFFFF_8AD0}, 1'b1, 1'b0},
        '{'{REQ_BEACON,       32'h0000_00AA, 4'd2,  1'b1, 1'b0, 1'b0, 32'hFFFF_8AD0}, 1'b1, 1'b0},
        '{'{REQ_DEFER_QUERY,  32'h0000_0000, 4'd2,  1'b1, 1'b0, 1'b0, 32'hFFFF_8AD0}, 1'b0, 1'b0},
        '{'{REQ_SKIPPED,      32'h0000_00AA, 4'd0,  1'b0, 1'b0, 1'b0, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{REQ_BEACON,       32'h0000_00AA, 4'd2,  1'b1, 1'b0, 1'b0, 32'h8000_0000}, 1'b0, 1'b0},
        '{'{REQ_FLUSHED,      32'h0000_0000, 4'd15, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF}, 1'b1, 1'b0},
        '{'{REQ_FLUSHED,      32'h0000_0000, 4'd2,  1'b1, 1'b0, 1'b0, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{REQ_FLUSHED,      32'h0000_0000, 4'd6,  1'b0, 1'b0, 1'b1, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{REQ_SLOT_CLEARED, 32'h0000_0000, 4'd15, 1'b0, 1'b0, 1'b0, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{REQ_DEFER_QUERY,  32'h0000_0000, 4'd15, 1'b1, 1'b0, 1'b0, 32'h0000_0000}, 1'b1, 1'b0},
        '{'{REQ_DEFER_QUERY,  32'h0000_0000, 4'd2,  1'b1, 1'b0, 1'b0, 32'h0000_0000}, 1'b0, 1'b0}
    };

    // Block ports, every input driven to a known value from time zero.
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_ready;
    logic [2:0]          i_req_type       = '0;
    logic [DATA_W-1:0]   i_peer_address   = '0;
    logic [SLOT_W-1:0]   i_slot_index     = '0;
    logic                i_slot_present   = 1'b0;
    logic                i_newly_admitted = 1'b0;
    logic                i_rows_found     = 1'b0;
    logic [DATA_W-1:0]   i_now_time       = '0;
    logic                o_out_valid;
    logic                i_out_ready      = 1'b0;
    logic                o_answer;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [ADDR_W-1:0]   paddr            = '0;
    logic [DATA_W-1:0]   pwdata           = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Scheduler state as the testbench expects it to be.
    logic [DATA_W-1:0]   sweep_cfg   = SWEEP_INTERVAL_RST;
    logic [DATA_W-1:0]   cool_cfg    = COOLDOWN_RST;
    logic [DATA_W-1:0]   sweep_due   = '0;
    logic [DATA_W-1:0]   hold_peer   = '0;
    logic [DATA_W-1:0]   hold_end    = '0;
    logic [DATA_W-1:0]   retry_at [SLOTS];

    // Answers still owed by the block, oldest first.
    t_awaited_answer     owed_answers [$];

    // Stimulus bookkeeping.
    logic [DATA_W-1:0]   now_ms      = '0;
    logic [DATA_W-1:0]   peer_pool [4];
    bit                  no_gaps     = 1'b0;
    int unsigned         out_stall   = 0;
    int unsigned         n_sent      = 0;
    int unsigned         n_checked   = 0;
    int unsigned         n_ones      = 0;
    int unsigned         n_settings  = 1;
    int unsigned         mismatches  = 0;

    parked_retry_deadline_scheduler_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_peer_address   (i_peer_address),
        .i_slot_index     (i_slot_index),
        .i_slot_present   (i_slot_present),
        .i_newly_admitted (i_newly_admitted),
        .i_rows_found     (i_rows_found),
        .i_now_time       (i_now_time),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_answer         (o_answer),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Clock with a period of 12 time units.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // A deadline has come once the wrapping difference from it is not negative.
    function automatic logic deadline_reached(input logic [DATA_W-1:0] at_ms,
                                              input logic [DATA_W-1:0] deadline);
        logic [DATA_W-1:0] delta;
        delta = at_ms - deadline;
        return (delta[DATA_W-1] == 1'b0);
    endfunction

    // A computed deadline of zero would read as disarmed, so it becomes one.
    function automatic logic [DATA_W-1:0] never_zero(input logic [DATA_W-1:0] t);
        return (t == '0) ? DATA_W'(1) : t;
    endfunction

    // Applies one event to the expected state and returns the answer it should give.
    function automatic logic scheduler_answer(input t_req ev);
        logic              in_range;
        logic              present;
        int unsigned       idx;
        logic              answer;
        logic              held;
        in_range = (int'(ev.slot_index) < SLOTS);
        present  = ev.slot_present && in_range;
        idx      = in_range ? int'(ev.slot_index) : 0;
        answer   = 1'b0;
        case (ev.req_type)
            REQ_SWEEP_CHECK: begin
                if (deadline_reached(ev.now_time, sweep_due)) begin
                    sweep_due = never_zero(ev.now_time + sweep_cfg);
                    answer    = 1'b1;
                end
            end
            REQ_SWEPT: begin
                hold_peer = ev.peer_address;
                hold_end  = never_zero(ev.now_time + cool_cfg);
            end
            REQ_SKIPPED: begin
                hold_peer = ev.peer_address;
                hold_end  = '0;
            end
            REQ_DEFER_QUERY: begin
                answer = present && (retry_at[idx] != '0);
            end
            REQ_ARM: begin
                if (present) begin
                    retry_at[idx] = never_zero(ev.now_time);
                    answer        = 1'b1;
                end
            end
            REQ_BEACON: begin
                // A beacon from the peer under an unexpired hold only pushes its retry out.
                held = (ev.peer_address != '0) && (ev.peer_address == hold_peer) &&
                       (hold_end != '0) && !deadline_reached(ev.now_time, hold_end);
                if (held) begin
                    if (present && ((retry_at[idx] == '0) ||
                                    deadline_reached(hold_end, retry_at[idx]))) begin
                        retry_at[idx] = hold_end;
                    end
                end else if (ev.newly_admitted) begin
                    answer = 1'b1;
                end else if (present && (retry_at[idx] != '0)) begin
                    answer = deadline_reached(ev.now_time, retry_at[idx]);
                end
            end
            REQ_FLUSHED: begin
                if (present) begin
                    retry_at[idx] = ev.rows_found ? never_zero(ev.now_time + cool_cfg) : '0;
                end
            end
            default: begin
                if (in_range) begin
                    retry_at[idx] = '0;
                end
            end
        endcase
        return answer;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random event: a small pool of peers so that holds get hit, and a mostly creeping clock.
    function automatic t_req random_event();
        t_req        ev;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)      ev.req_type = REQ_SWEEP_CHECK;
        else if (roll < 25) ev.req_type = REQ_SWEPT;
        else if (roll < 30) ev.req_type = REQ_SKIPPED;
        else if (roll < 40) ev.req_type = REQ_DEFER_QUERY;
        else if (roll < 55) ev.req_type = REQ_ARM;
        else if (roll < 80) ev.req_type = REQ_BEACON;
        else if (roll < 92) ev.req_type = REQ_FLUSHED;
        else                ev.req_type = REQ_SLOT_CLEARED;
        ev.peer_address   = ($urandom_range(0, 99) < 75) ? peer_pool[$urandom_range(0, 3)]
                                                         : DATA_W'($urandom);
        ev.slot_index     = SLOT_W'($urandom_range(0, SLOTS - 1));
        ev.slot_present   = ($urandom_range(0, 99) < 85);
        ev.newly_admitted = ($urandom_range(0, 99) < 20);
        ev.rows_found     = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 50)      now_ms = now_ms + $urandom_range(0, 300);
        else if (roll < 85) now_ms = now_ms + $urandom_range(0, 40000);
        else if (roll < 95) now_ms = DATA_W'($urandom);
        ev.now_time       = now_ms;
        return ev;
    endfunction

    // Counts a failure and reports the first few of them.
    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", what);
        end
    endtask

    // Offers one event and waits for its transfer; the answer it earns is queued.
    task automatic send_event(input t_req ev, input logic typed, input logic typed_answer);
        logic            predicted;
        t_awaited_answer owed;
        i_in_valid       <= 1'b1;
        i_req_type       <= ev.req_type;
        i_peer_address   <= ev.peer_address;
        i_slot_index     <= ev.slot_index;
        i_slot_present   <= ev.slot_present;
        i_newly_admitted <= ev.newly_admitted;
        i_rows_found     <= ev.rows_found;
        i_now_time       <= ev.now_time;
        do @(posedge i_clk); while (!o_in_ready);
        predicted   = scheduler_answer(ev);
        owed.kind   = ev.req_type;
        owed.answer = typed ? typed_answer : predicted;
        owed_answers.push_back(owed);
        n_sent++;
    endtask

    // Sender idles for a random while after a transfer, unless gaps are turned off.
    task automatic sender_gap();
        int unsigned cycles;
        cycles = no_gaps ? 0 : pick_gap();
        if (cycles != 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every owed answer has come out.
    task automatic drain_answers();
        i_in_valid <= 1'b0;
        while (owed_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register over APB, then reads it back.
    task automatic set_register(input logic idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_SWEEP_INTERVAL) sweep_cfg = value;
        else                           cool_cfg  = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            note_mismatch($sformatf("register %0d read back %h, expected %h",
                                    idx, prdata, value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stalls on the ready, or none at all in a steady phase.
    always @(posedge i_clk) begin
        if (no_gaps) begin
            i_out_ready <= 1'b1;
            out_stall   <= 0;
        end else if (out_stall != 0) begin
            i_out_ready <= 1'b0;
            out_stall   <= out_stall - 1;
        end else begin
            automatic int unsigned stall = pick_gap();
            i_out_ready <= (stall == 0);
            out_stall   <= (stall == 0) ? 0 : stall - 1;
        end
    end

    // Every answer transfer is compared with the oldest owed answer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_answers.size() == 0) begin
                note_mismatch($sformatf("unexpected answer %b with nothing owed", o_answer));
            end else begin
                automatic t_awaited_answer owed = owed_answers.pop_front();
                if (o_answer !== owed.answer) begin
                    note_mismatch($sformatf("answer %0d (%s): expected %b, got %b",
                                            n_checked, owed.kind.name(), owed.answer,
                                            o_answer));
                end
                n_ones    += (o_answer === 1'b1);
                n_checked++;
            end
        end
    end

    // Main sequence: reset, directed table, then random phases under several settings.
    initial begin
        foreach (retry_at[s]) retry_at[s] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            send_event(DIRECTED[r].ev, DIRECTED[r].typed, DIRECTED[r].answer);
            sender_gap();
        end
        drain_answers();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Settings change only once the block has nothing in flight.
            if (phase != 0) begin
                drain_answers();
                case (phase)
                    1: begin
                        set_register(REG_SWEEP_INTERVAL, 32'h0000_0000);
                        set_register(REG_COOLDOWN,       32'h0000_0000);
                    end
                    2: begin
                        set_register(REG_SWEEP_INTERVAL, 32'hFFFF_FFFF);
                        set_register(REG_COOLDOWN,       32'hFFFF_FFFF);
                    end
                    3: begin
                        set_register(REG_SWEEP_INTERVAL, 32'd500);
                        set_register(REG_COOLDOWN,       32'd200);
                    end
                    4: begin
                        set_register(REG_SWEEP_INTERVAL, DATA_W'($urandom));
                        set_register(REG_COOLDOWN,       DATA_W'($urandom_range(1, 100000)));
                    end
                    default: begin
                        set_register(REG_SWEEP_INTERVAL, 32'h8000_0000);
                        set_register(REG_COOLDOWN,       32'h7FFF_FFFF);
                    end
                endcase
                n_settings++;
            end
            peer_pool[0] = '0;
            peer_pool[1] = '1;
            peer_pool[2] = DATA_W'($urandom);
            peer_pool[3] = DATA_W'($urandom);
            no_gaps = (phase == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_event(random_event(), 1'b0, 1'b0);
                sender_gap();
            end
        end

        drain_answers();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d events (%0d directed) under %0d register settings.",
                 n_sent, NUM_DIRECTED, n_settings);
        $display("Checked %0d answers, %0d of them set; %0d failures.",
                 n_checked, n_ones, mismatches);
        if (mismatches == 0) begin
            $display("parked_retry_deadline_scheduler_top: match");
        end else begin
            $display("parked_retry_deadline_scheduler_top: mismatch");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #12000000;
        $display("Timed out with %0d answers still owed.", owed_answers.size());
        $display("parked_retry_deadline_scheduler_top: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
src/prds_pkg.sv
src/prds_cfg.sv
src/prds_core.sv
src/parked_retry_deadline_scheduler_top.sv
tb/tb_parked_retry_deadline_scheduler_top.sv
